/* hdl/cursor_overlay_alpha_blend_macros.svh */
// Assertion macros shared by the RTL of the cursor overlay block.
// Define ASSERT_OFF to compile the assertions away.
`ifndef CURSOR_OVERLAY_ALPHA_BLEND_MACROS_SVH
`define CURSOR_OVERLAY_ALPHA_BLEND_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define COAB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define COAB_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define COAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/coab_pkg.sv */
`default_nettype none

package coab_pkg;

   // Default sizes of the cursor store and of the frame.
   localparam int CURSOR_MAX_DIM_DEFAULT = 64;
   localparam int FRAME_MAX_DIM_DEFAULT  = 8192;

   // Fixed widths of the ports.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 14;
   localparam int REQ_DATA_WIDTH = 72;
   localparam int REQ_USER_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = 24;
   localparam int CHANNELS       = 3;

   // Alpha codes with a fixed meaning and the rounding offset of the blend.
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ROUND_HALF   = 8'd127;

   // Input kind carried in the request user bits.
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_CURSOR_LEFT = 3'd0,
      CSR_CURSOR_TOP  = 3'd1,
      CSR_CURSOR_COLS = 3'd2,
      CSR_CURSOR_ROWS = 3'd3,
      CSR_FRAME_COLS  = 3'd4,
      CSR_FRAME_ROWS  = 3'd5
   } csr_index_type;

   // Three channel bytes, channel 0 in the lowest byte.
   typedef logic [CHANNELS-1:0][7:0] pixel_type;

endpackage

`default_nettype wire

/* hdl/coab_blend.sv */
`default_nettype none

module coab_blend
   import coab_pkg::*;
(
   input  wire logic [31:0] cursor_word,
   input  wire pixel_type   frame_pixel,
   input  wire logic        covered,
   output pixel_type        blend_pixel
);

   logic [7:0] alpha;
   logic [7:0] inv_alpha;

   assign alpha     = cursor_word[31:24];
   assign inv_alpha = ALPHA_OPAQUE - alpha;

   // Covered, alpha not clear: colour + round(frame * (255 - alpha) / 255), wrapped to 8 bits.
   // The division by 255 is (x + (x >> 8) + 1) >> 8, exact for x below 65535.
   always_comb begin
      logic [15:0] scaled;
      logic [16:0] approx;
      logic [7:0]  colour;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         colour = cursor_word[8*ch +: 8];
         scaled = 16'(frame_pixel[ch] * inv_alpha) + 16'(ROUND_HALF);
         approx = 17'(scaled) + 17'(scaled[15:8]) + 17'd1;
         if (!covered || alpha == ALPHA_CLEAR) begin
            blend_pixel[ch] = frame_pixel[ch];
         end else if (alpha == ALPHA_OPAQUE) begin
            blend_pixel[ch] = colour;
         end else begin
            blend_pixel[ch] = colour + approx[15:8];
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/cursor_overlay_alpha_blend.sv */
`default_nettype none

// Cursor overlay: draws a stored cursor image of up to CURSOR_MAX_DIM squared
// 32-bit words (alpha in the top byte, premultiplied colour below) over a raster
// stream of frame pixels. The block accepts one item per clock while the result
// stream is not stalled. A load item writes one word into the cursor memory and
// gives no result; a pixel item gives one result, through the registered read of
// the cursor memory and then the blend into the output register. The raster
// position advances on each pixel and is reset by start_of_frame in
// the request user bits. The cursor memory is not cleared after reset: a covered
// pixel must only read words that were loaded before. Configuration writes are
// meant for idle periods only.
module cursor_overlay_alpha_blend
   import coab_pkg::*;
#(
   parameter int CURSOR_MAX_DIM = CURSOR_MAX_DIM_DEFAULT,
   parameter int FRAME_MAX_DIM  = FRAME_MAX_DIM_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Configuration write port.
   input  wire logic                      csr_we,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   // Request stream.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: load_index[11:0], cursor_word[43:12], pixel_c0[51:44],
   // pixel_c1[59:52], pixel_c2[67:60], zero fill[71:68].
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // Fields from bit 0: action[0], start_of_frame[1].
   input  wire logic [REQ_USER_WIDTH-1:0] req_tuser,
   // Result stream.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // Fields from bit 0: out_c0[7:0], out_c1[15:8], out_c2[23:16].
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   // Fields from bit 0: covered[0].
   output logic [0:0]                     rsp_tuser
);

   localparam int STORE_DEPTH = CURSOR_MAX_DIM * CURSOR_MAX_DIM;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int CDW         = $clog2(CURSOR_MAX_DIM + 1);
   localparam int FW          = $clog2(FRAME_MAX_DIM + 1);
   localparam int RW          = $clog2(FRAME_MAX_DIM);
   localparam int DXW         = ((RW + 1 > CSR_DATA_WIDTH) ? RW + 1 : CSR_DATA_WIDTH) + 1;

   // Configuration registers.
   logic signed [13:0] left_ff, left_in;
   logic signed [13:0] top_ff, top_in;
   logic [6:0]         ccols_ff, ccols_in;
   logic [6:0]         crows_ff, crows_in;
   logic [13:0]        fcols_ff, fcols_in;
   logic [13:0]        frows_ff, frows_in;

   // Raster position of the next pixel.
   logic [RW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Memory stage and output stage.
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pix_ff;
   logic          s1_cov_ff;
   logic [31:0]   rdata_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_pix_ff;
   logic          rsp_cov_ff;

   logic [31:0]   cursor_mem [STORE_DEPTH];

   // Request fields.
   logic          req_action;
   logic          req_sof;
   logic [11:0]   req_load_index;
   logic [31:0]   req_word;
   pixel_type     req_pix;

   logic          req_xfer;
   logic          pix_xfer;
   logic          load_xfer;
   logic          out_en;

   logic [CDW-1:0]       cc;
   logic [CDW-1:0]       cr;
   logic [FW-1:0]        fc;
   logic [FW-1:0]        fr;
   logic [RW-1:0]        col0;
   logic [RW-1:0]        row0;
   logic [RW:0]          col1;
   logic [RW:0]          row1;
   logic signed [DXW-1:0] dx;
   logic signed [DXW-1:0] dy;
   logic                  hit;
   logic [2*CDW:0]        rd_index;
   logic [AW-1:0]         rd_addr;
   logic [31:0]           load_index_ext;
   pixel_type             blend_pix;

   assign req_action     = req_tuser[0];
   assign req_sof        = req_tuser[1];
   assign req_load_index = req_tdata[11:0];
   assign req_word       = req_tdata[43:12];
   assign req_pix        = req_tdata[67:44];

   // Handshake: the memory stage takes a new item whenever it is empty or can move on.
   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_en;
   assign req_xfer   = req_tvalid && req_tready;
   assign pix_xfer   = req_xfer && (req_action == ACTION_PIXEL);
   assign load_xfer  = req_xfer && (req_action == ACTION_LOAD);

   // Configuration write decode.
   always_comb begin
      left_in  = left_ff;
      top_in   = top_ff;
      ccols_in = ccols_ff;
      crows_in = crows_ff;
      fcols_in = fcols_ff;
      frows_in = frows_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CURSOR_LEFT: left_in  = csr_wdata;
            CSR_CURSOR_TOP:  top_in   = csr_wdata;
            CSR_CURSOR_COLS: ccols_in = csr_wdata[6:0];
            CSR_CURSOR_ROWS: crows_in = csr_wdata[6:0];
            CSR_FRAME_COLS:  fcols_in = csr_wdata;
            CSR_FRAME_ROWS:  frows_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Saturate the sizes into their legal ranges.
   always_comb begin
      cc = (32'(ccols_ff) > 32'(CURSOR_MAX_DIM)) ? CDW'(CURSOR_MAX_DIM) : CDW'(ccols_ff);
      cr = (32'(crows_ff) > 32'(CURSOR_MAX_DIM)) ? CDW'(CURSOR_MAX_DIM) : CDW'(crows_ff);
      if (fcols_ff == 14'd0) begin
         fc = FW'(1);
      end else if (32'(fcols_ff) > 32'(FRAME_MAX_DIM)) begin
         fc = FW'(FRAME_MAX_DIM);
      end else begin
         fc = FW'(fcols_ff);
      end
      if (frows_ff == 14'd0) begin
         fr = FW'(1);
      end else if (32'(frows_ff) > 32'(FRAME_MAX_DIM)) begin
         fr = FW'(FRAME_MAX_DIM);
      end else begin
         fr = FW'(frows_ff);
      end
   end

   // Position of this pixel, cursor hit test and memory address.
   always_comb begin
      col0 = req_sof ? '0 : col_ff;
      row0 = req_sof ? '0 : row_ff;
      if (32'(col0) >= 32'(fc)) begin
         col0 = '0;
      end
      if (32'(row0) >= 32'(fr)) begin
         row0 = '0;
      end
      dx = DXW'($signed({1'b0, col0})) - DXW'(left_ff);
      dy = DXW'($signed({1'b0, row0})) - DXW'(top_ff);
      hit = !dx[DXW-1] && !dy[DXW-1] &&
            ($unsigned(dx) < DXW'(cc)) && ($unsigned(dy) < DXW'(cr));
      rd_index = (2*CDW+1)'(dy[CDW-1:0] * cc) + (2*CDW+1)'(dx[CDW-1:0]);
      rd_addr  = rd_index[AW-1:0];
   end

   // Raster advance: wrap at the end of the row, then at the end of the frame.
   always_comb begin
      col1   = (RW+1)'(col0) + (RW+1)'(1);
      row1   = (RW+1)'(row0) + (RW+1)'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (pix_xfer) begin
         if (32'(col1) >= 32'(fc)) begin
            col_in = '0;
            row_in = (32'(row1) >= 32'(fr)) ? '0 : row1[RW-1:0];
         end else begin
            col_in = col1[RW-1:0];
            row_in = row0;
         end
      end
   end

   // Pipeline valid bits.
   always_comb begin
      if (pix_xfer) begin
         s1_valid_in = 1'b1;
      end else if (out_en) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         top_ff       <= '0;
         ccols_ff     <= '0;
         crows_ff     <= '0;
         fcols_ff     <= 14'd1;
         frows_ff     <= 14'd1;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         top_ff       <= top_in;
         ccols_ff     <= ccols_in;
         crows_ff     <= crows_in;
         fcols_ff     <= fcols_in;
         frows_ff     <= frows_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Cursor memory: loads beyond the store are dropped.
   assign load_index_ext = 32'(req_load_index);

   always_ff @(posedge clock) begin
      if (load_xfer && (load_index_ext < 32'(STORE_DEPTH))) begin
         cursor_mem[load_index_ext[AW-1:0]] <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_xfer) begin
         rdata_ff <= cursor_mem[rd_addr];
      end
   end

   // Memory stage payload.
   always_ff @(posedge clock) begin
      if (pix_xfer) begin
         s1_pix_ff <= req_pix;
         s1_cov_ff <= hit;
      end
   end

   coab_blend u_blend (
      .cursor_word (rdata_ff),
      .frame_pixel (s1_pix_ff),
      .covered     (s1_cov_ff),
      .blend_pixel (blend_pix)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_pix_ff <= blend_pix;
         rsp_cov_ff <= s1_cov_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pix_ff;
   assign rsp_tuser[0] = rsp_cov_ff;

`include "cursor_overlay_alpha_blend_macros.svh"

   // An accepted pixel always lands in the memory stage.
   `COAB_ASSERT_NEXT(a_pix_enters_s1, clock, reset, pix_xfer, s1_valid_ff, "pixel transfer lost")

   // A stalled memory stage keeps its item.
   `COAB_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !out_en, s1_valid_ff, "stage item dropped")

   // An uncovered pixel leaves the block unchanged.
   `COAB_ASSERT_NEXT(a_uncovered_pass, clock, reset, s1_valid_ff && out_en && !s1_cov_ff, rsp_tvalid && rsp_tdata == $past(s1_pix_ff), "uncovered pixel changed")

   // A load never makes the memory stage busy on its own.
   `COAB_ASSERT_NEXT(a_load_no_result, clock, reset, load_xfer && !s1_valid_ff, !s1_valid_ff, "load produced a result")

endmodule

`default_nettype wire

/* tb/cursor_overlay_alpha_blend_tb.sv */
`default_nettype none

module cursor_overlay_alpha_blend_tb;
   import coab_pkg::*;

   localparam int STORE_DEPTH = CURSOR_MAX_DIM_DEFAULT * CURSOR_MAX_DIM_DEFAULT;
   localparam int QUIET_LIMIT = 3000;
   localparam int TARGET_ITEMS = 1450;
   localparam int PHASE_PIXELS = 80;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One request item as the block sees it.
   typedef struct {
      logic        action;
      logic [11:0] load_index;
      logic [31:0] cursor_word;
      logic        sof;
      pixel_type   pixel;
   } overlay_item_type;

   // One composited pixel.
   typedef struct {
      pixel_type pixel;
      logic      covered;
   } blend_result_type;

   // Register values of one configuration phase.
   typedef struct {
      logic [13:0] left;
      logic [13:0] top;
      logic [6:0]  ccols;
      logic [6:0]  crows;
      logic [13:0] fcols;
      logic [13:0] frows;
   } overlay_cfg_type;

   // Tracks the cursor memory, raster position and registers, and holds the
   // composited pixels still to come out of the block.
   class overlay_scoreboard;
      logic [31:0] cursor_mem [STORE_DEPTH];
      bit          loaded [STORE_DEPTH];
      int unsigned col, row;
      logic [13:0] left_q, top_q, fcols_q, frows_q;
      logic [6:0]  ccols_q, crows_q;
      blend_result_type expected_blend_q [$];
      int          errors;

      function new();
         col = 0;
         row = 0;
         left_q = '0;
         top_q = '0;
         ccols_q = '0;
         crows_q = '0;
         fcols_q = 14'd1;
         frows_q = 14'd1;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void write_reg(csr_index_type k, logic [13:0] v);
         case (k)
            CSR_CURSOR_LEFT: left_q = v;
            CSR_CURSOR_TOP:  top_q = v;
            CSR_CURSOR_COLS: ccols_q = v[6:0];
            CSR_CURSOR_ROWS: crows_q = v[6:0];
            CSR_FRAME_COLS:  fcols_q = v;
            CSR_FRAME_ROWS:  frows_q = v;
            default: ;
         endcase
      endfunction

      function int cursor_dim(logic [6:0] v);
         return (v > CURSOR_MAX_DIM_DEFAULT) ? CURSOR_MAX_DIM_DEFAULT : int'(v);
      endfunction

      function int frame_dim(logic [13:0] v);
         if (v == 0) return 1;
         return (v > FRAME_MAX_DIM_DEFAULT) ? FRAME_MAX_DIM_DEFAULT : int'(v);
      endfunction

      // Start of frame and a shrunken frame both pull the position back in.
      function void align(bit sof);
         if (sof) begin
            col = 0;
            row = 0;
         end
         if (col >= frame_dim(fcols_q)) col = 0;
         if (row >= frame_dim(frows_q)) row = 0;
      endfunction

      // Memory index under the current position, or -1 outside the cursor.
      function int store_index();
         int lx, ty, dx, dy, cc, cr;
         lx = $signed(left_q);
         ty = $signed(top_q);
         dx = int'(col) - lx;
         dy = int'(row) - ty;
         cc = cursor_dim(ccols_q);
         cr = cursor_dim(crows_q);
         if (dx >= 0 && dy >= 0 && dx < cc && dy < cr) return dy * cc + dx;
         return -1;
      endfunction

      // Index the next pixel would read, leaving the position untouched.
      function int peek_index(bit sof);
         int unsigned c, r;
         int i;
         c = col;
         r = row;
         align(sof);
         i = store_index();
         col = c;
         row = r;
         return i;
      endfunction

      function logic [7:0] mix_channel(logic [7:0] colour, logic [7:0] frame,
                                       logic [7:0] alpha);
         int unsigned f, a, kept;
         f = frame;
         a = alpha;
         kept = (f * (int'(ALPHA_OPAQUE) - a) + int'(ROUND_HALF)) / int'(ALPHA_OPAQUE);
         return 8'(int'(colour) + kept);
      endfunction

      function void note_input(overlay_item_type it);
         blend_result_type res;
         logic [31:0] w;
         logic [7:0] a;
         int idx;
         if (it.action == ACTION_LOAD) begin
            cursor_mem[it.load_index] = it.cursor_word;
            loaded[it.load_index] = 1'b1;
            return;
         end
         align(it.sof);
         idx = store_index();
         res.pixel = it.pixel;
         res.covered = 1'b0;
         if (idx >= 0) begin
            w = cursor_mem[idx];
            a = w[31:24];
            res.covered = 1'b1;
            if (a == ALPHA_OPAQUE) begin
               res.pixel = w[23:0];
            end else if (a != ALPHA_CLEAR) begin
               for (int ch = 0; ch < CHANNELS; ch++)
                  res.pixel[ch] = mix_channel(w[8*ch +: 8], it.pixel[ch], a);
            end
         end
         expected_blend_q.push_back(res);
         // Step along the raster, wrapping at the end of a row and of the frame.
         col++;
         if (col >= frame_dim(fcols_q)) begin
            col = 0;
            row++;
            if (row >= frame_dim(frows_q)) row = 0;
         end
      endfunction

      task check_result(pixel_type pix, logic cov);
         blend_result_type exp_res;
         if (expected_blend_q.size() == 0) begin
            report($sformatf("unexpected pixel %h covered %b", pix, cov));
            return;
         end
         exp_res = expected_blend_q.pop_front();
         for (int ch = 0; ch < CHANNELS; ch++)
            if (pix[ch] !== exp_res.pixel[ch])
               report($sformatf("out_c%0d is %h, expected %h", ch, pix[ch],
                                exp_res.pixel[ch]));
         if (cov !== exp_res.covered)
            report($sformatf("covered is %b, expected %b", cov, exp_res.covered));
      endtask

      function int pending();
         return expected_blend_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // Fields from bit 0: load_index, cursor_word, pixel_c0, pixel_c1, pixel_c2, zero fill.
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   // Fields from bit 0: action, start_of_frame.
   logic [REQ_USER_WIDTH-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // Fields from bit 0: out_c0, out_c1, out_c2.
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   // Fields from bit 0: covered.
   logic [0:0]                rsp_tuser;

   overlay_scoreboard sb;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   cursor_overlay_alpha_blend dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check every result transfer against the oldest expected pixel.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser[0]);
   end

   // Count cycles in which nothing moves on either stream or the register port.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   function pixel_type random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return 24'($urandom);
      endcase
   endfunction

   // Alpha is clear, opaque or anything in between, colour bytes are arbitrary.
   function logic [31:0] random_cursor_word();
      logic [7:0] a;
      case ($urandom_range(3))
         0: a = ALPHA_CLEAR;
         1: a = ALPHA_OPAQUE;
         default: a = 8'($urandom);
      endcase
      return {a, 24'($urandom)};
   endfunction

   function void set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_gap_pct = 54; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 54; end
         default:       begin send_gap_pct = 27; recv_stall_pct = 27; end
      endcase
   endfunction

   // Drive one item, holding it until the transfer, then record it.
   task send_item(overlay_item_type it);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, it.pixel, it.cursor_word, it.load_index};
      req_tuser <= {it.sof, it.action};
      do @(posedge clock); while (!req_tready);
      sb.note_input(it);
      items_sent++;
   endtask

   task send_load(logic [11:0] idx, logic [31:0] word);
      overlay_item_type it;
      it.action = ACTION_LOAD;
      it.load_index = idx;
      it.cursor_word = word;
      it.sof = 1'($urandom);
      it.pixel = 24'($urandom);
      send_item(it);
   endtask

   // A covered pixel must never read an unwritten word, so load it first.
   task send_pixel(bit sof, pixel_type pix);
      overlay_item_type it;
      int idx;
      idx = sb.peek_index(sof);
      if (idx >= 0 && !sb.loaded[idx]) send_load(12'(idx), random_cursor_word());
      it.action = ACTION_PIXEL;
      it.load_index = 12'($urandom);
      it.cursor_word = $urandom;
      it.sof = sof;
      it.pixel = pix;
      send_item(it);
   endtask

   task wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(csr_index_type k, logic [13:0] v);
      csr_we <= 1'b1;
      csr_addr <= k;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(k, v);
   endtask

   task set_registers(overlay_cfg_type cfg);
      write_reg(CSR_CURSOR_LEFT, cfg.left);
      write_reg(CSR_CURSOR_TOP, cfg.top);
      write_reg(CSR_CURSOR_COLS, 14'(cfg.ccols));
      write_reg(CSR_CURSOR_ROWS, 14'(cfg.crows));
      write_reg(CSR_FRAME_COLS, cfg.fcols);
      write_reg(CSR_FRAME_ROWS, cfg.frows);
      csr_we <= 1'b0;
   endtask

   // One phase: new registers, a fresh cursor image where it is small, then a
   // pixel stream with a few stray loads and restarts of the frame.
   task run_phase(overlay_cfg_type cfg, idle_mode_type mode);
      int area;
      wait_idle();
      set_registers(cfg);
      set_idling(mode);
      area = sb.cursor_dim(cfg.ccols) * sb.cursor_dim(cfg.crows);
      if (area <= 100)
         for (int i = 0; i < area; i++) send_load(12'(i), random_cursor_word());
      for (int k = 0; k < PHASE_PIXELS; k++) begin
         if ($urandom_range(99) < 8)
            send_load(12'($urandom_range(area > 0 ? area - 1 : STORE_DEPTH - 1)),
                      random_cursor_word());
         send_pixel(k == 0 || $urandom_range(39) == 0, random_pixel());
      end
   endtask

   overlay_cfg_type fixed_cfgs [11] = '{
      '{-2, -1, 5, 4, 7, 5},
      '{5, 3, 8, 8, 10, 6},
      '{-128, -128, 127, 127, 16, 16},
      '{-60, -62, 64, 64, 20, 12},
      '{8191, 8191, 3, 3, 0, 0},
      '{0, 0, 64, 64, 16383, 2},
      '{3, 2, 0, 5, 8, 8},
      '{-8192, 0, 6, 6, 8, 8},
      '{0, 0, 1, 1, 1, 1},
      '{0, 0, 2, 3, 3, 16383},
      '{1, 1, 16, 16, 20, 20}
   };

   logic [31:0] directed_words [8] = '{
      32'h00A5A5A5, 32'hFF123456, 32'h01FFFFFF, 32'hFE000000,
      32'h80804020, 32'h7F7F7F7F, 32'hFFFFFFFF, 32'h01000000
   };

   initial begin
      overlay_cfg_type cfg;
      int phase;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: a one-pixel frame and an empty cursor.
      for (int k = 0; k < 3; k++) send_pixel(k == 0, random_pixel());

      // Small frame with the cursor fully inside it: clear, opaque, overflowing
      // and intermediate alpha over black, white and random frame pixels.
      wait_idle();
      set_registers('{1, 0, 4, 2, 6, 3});
      for (int i = 0; i < 8; i++) send_load(12'(i), directed_words[i]);
      for (int k = 0; k < 20; k++)
         send_pixel(k == 0, (k % 3 == 0) ? pixel_type'('1) :
                            (k % 3 == 1) ? pixel_type'('0) : random_pixel());

      // Register extremes and clipping cases, then random placements.
      phase = 0;
      foreach (fixed_cfgs[i]) begin
         run_phase(fixed_cfgs[i], idle_mode_type'(phase % 4));
         phase++;
      end
      while (items_sent < TARGET_ITEMS) begin
         cfg.left = 14'($urandom_range(20)) - 14'd8;
         cfg.top = 14'($urandom_range(16)) - 14'd6;
         cfg.ccols = 7'($urandom_range(10));
         cfg.crows = 7'($urandom_range(10));
         cfg.fcols = 14'($urandom_range(16));
         cfg.frows = 14'($urandom_range(12));
         run_phase(cfg, idle_mode_type'(phase % 4));
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
